// ===== hw/rtl/lrc_pkg.sv =====
// Shared types and constants for the line rectangle clipper.
`default_nettype none

package lrc_pkg;

   // Width of the configuration register index.
   localparam int CSR_INDEX_BITS = 2;

   // Reset values of the window registers, truncated to the coordinate width on use.
   localparam int RESET_LEFT   = 0;
   localparam int RESET_RIGHT  = 639;
   localparam int RESET_TOP    = 0;
   localparam int RESET_BOTTOM = 479;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_LEFT   = 2'd0,
      CSR_RIGHT  = 2'd1,
      CSR_TOP    = 2'd2,
      CSR_BOTTOM = 2'd3
   } lrc_csr_type;

   // Control bits that travel with a line through the clip stages.
   typedef struct packed {
      logic valid;
      logic rej;
      logic flip;
   } lrc_ctl_type;

endpackage

`default_nettype wire

// ===== hw/rtl/lrc_div.sv =====
// Pipelined signed divider, one quotient bit per stage, truncating toward zero.
`default_nettype none

module lrc_div #(
   parameter int NUM_BITS  = 34,
   parameter int DEN_BITS  = 17,
   parameter int SIDE_BITS = 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        enable,
   input  logic                        in_valid,
   input  logic signed [NUM_BITS-1:0]  in_num,
   input  logic signed [DEN_BITS-1:0]  in_den,
   input  logic        [SIDE_BITS-1:0] in_side,
   output logic                        out_valid,
   output logic signed [NUM_BITS-1:0]  out_quo,
   output logic        [SIDE_BITS-1:0] out_side
);

   // Per-stage registers; stage 0 holds the operand magnitudes.
   logic                 valid_ff [0:NUM_BITS];
   logic [DEN_BITS-1:0]  rem_ff   [0:NUM_BITS];
   logic [NUM_BITS-1:0]  nq_ff    [0:NUM_BITS];
   logic [DEN_BITS-1:0]  den_ff   [0:NUM_BITS];
   logic                 neg_ff   [0:NUM_BITS];
   logic                 zero_ff  [0:NUM_BITS];
   logic [SIDE_BITS-1:0] side_ff  [0:NUM_BITS];

   logic [NUM_BITS-1:0] num_mag_in;
   logic [DEN_BITS-1:0] den_mag_in;

   logic                       out_valid_ff;
   logic signed [NUM_BITS-1:0] out_quo_ff;
   logic [SIDE_BITS-1:0]       out_side_ff;
   logic signed [NUM_BITS-1:0] quo_in;

   // Take magnitudes of both operands and note the sign of the quotient.
   always_comb begin
      num_mag_in = in_num[NUM_BITS-1] ? NUM_BITS'(-in_num) : NUM_BITS'(in_num);
      den_mag_in = in_den[DEN_BITS-1] ? DEN_BITS'(-in_den) : DEN_BITS'(in_den);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff[0] <= 1'b0;
      end else if (enable) begin
         valid_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff[0]  <= '0;
         nq_ff[0]   <= num_mag_in;
         den_ff[0]  <= den_mag_in;
         neg_ff[0]  <= in_num[NUM_BITS-1] ^ in_den[DEN_BITS-1];
         zero_ff[0] <= (in_den == '0);
         side_ff[0] <= in_side;
      end
   end

   // One restoring step per stage: shift in the next dividend bit, subtract if it fits.
   for (genvar s = 0; s < NUM_BITS; s++) begin : g_step
      logic [DEN_BITS:0] shifted;
      logic [DEN_BITS:0] trial;
      logic              fits;

      always_comb begin
         shifted = {rem_ff[s], nq_ff[s][NUM_BITS-1]};
         trial   = shifted - {1'b0, den_ff[s]};
         fits    = (shifted >= {1'b0, den_ff[s]});
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s+1] <= 1'b0;
         end else if (enable) begin
            valid_ff[s+1] <= valid_ff[s];
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[s+1]  <= fits ? trial[DEN_BITS-1:0] : shifted[DEN_BITS-1:0];
            nq_ff[s+1]   <= {nq_ff[s][NUM_BITS-2:0], fits};
            den_ff[s+1]  <= den_ff[s];
            neg_ff[s+1]  <= neg_ff[s];
            zero_ff[s+1] <= zero_ff[s];
            side_ff[s+1] <= side_ff[s];
         end
      end
   end

   // Restore the sign; a zero divisor yields zero.
   always_comb begin
      if (zero_ff[NUM_BITS]) begin
         quo_in = '0;
      end else if (neg_ff[NUM_BITS]) begin
         quo_in = -$signed(nq_ff[NUM_BITS]);
      end else begin
         quo_in = $signed(nq_ff[NUM_BITS]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (enable) begin
         out_valid_ff <= valid_ff[NUM_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         out_quo_ff  <= quo_in;
         out_side_ff <= side_ff[NUM_BITS];
      end
   end

   assign out_valid = out_valid_ff;
   assign out_quo   = out_quo_ff;
   assign out_side  = out_side_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/lrc_axis.sv =====
// Clips a line against the low and high bounds of one axis, with reject test and ordering.
`default_nettype none

module lrc_axis #(
   parameter int CW        = 16,
   parameter int SIDE_BITS = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     enable,
   input  lrc_pkg::lrc_ctl_type     in_ctl,
   input  logic signed [CW-1:0]     in_p1,
   input  logic signed [CW-1:0]     in_q1,
   input  logic signed [CW-1:0]     in_p2,
   input  logic signed [CW-1:0]     in_q2,
   input  logic signed [CW-1:0]     in_lo,
   input  logic signed [CW-1:0]     in_hi,
   input  logic [SIDE_BITS-1:0]     in_side,
   output lrc_pkg::lrc_ctl_type     out_ctl,
   output logic signed [CW-1:0]     out_p1,
   output logic signed [CW-1:0]     out_q1,
   output logic signed [CW-1:0]     out_p2,
   output logic signed [CW-1:0]     out_q2,
   output logic [SIDE_BITS-1:0]     out_side
);
   import lrc_pkg::*;

   localparam int DW  = CW + 1;
   localparam int LNW = 2 * DW;
   localparam int RNW = 2 * CW + 3;
   localparam int LSW = SIDE_BITS + 3 + 4 * CW;
   localparam int RSW = SIDE_BITS + 4 + 4 * CW;
   localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
   localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

   // Clamp a wide signed value to the coordinate range.
   function automatic logic signed [CW-1:0] sat_coord(input logic signed [RNW-1:0] v);
      logic [RNW-CW:0] upper;
      upper = v[RNW-1:CW-1];
      if ((&upper) || (~|upper)) begin
         sat_coord = v[CW-1:0];
      end else if (v[RNW-1]) begin
         sat_coord = CMIN;
      end else begin
         sat_coord = CMAX;
      end
   endfunction

   // ---------------- Stage A0: reject test, ordering, low-clip differences.
   logic                   swap_in, rej_in, apl_in;
   logic signed [CW-1:0]   p1s_in, q1s_in, p2s_in, q2s_in;
   logic signed [DW-1:0]   dl_in, dq_in, den_in;

   always_comb begin
      rej_in  = in_ctl.rej || (in_p1 > in_hi && in_p2 > in_hi) ||
                (in_p1 < in_lo && in_p2 < in_lo);
      swap_in = (in_p1 > in_p2);
      p1s_in  = swap_in ? in_p2 : in_p1;
      q1s_in  = swap_in ? in_q2 : in_q1;
      p2s_in  = swap_in ? in_p1 : in_p2;
      q2s_in  = swap_in ? in_q1 : in_q2;
      apl_in  = (p1s_in < in_lo);
      dl_in   = {in_lo[CW-1], in_lo} - {p1s_in[CW-1], p1s_in};
      dq_in   = {q2s_in[CW-1], q2s_in} - {q1s_in[CW-1], q1s_in};
      den_in  = {p2s_in[CW-1], p2s_in} - {p1s_in[CW-1], p1s_in};
   end

   logic                  a0_valid_ff, a0_rej_ff, a0_flip_ff, a0_apl_ff;
   logic signed [CW-1:0]  a0_p1_ff, a0_q1_ff, a0_p2_ff, a0_q2_ff;
   logic signed [DW-1:0]  a0_dl_ff, a0_dq_ff, a0_den_ff;
   logic [SIDE_BITS-1:0]  a0_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a0_valid_ff <= 1'b0;
      end else if (enable) begin
         a0_valid_ff <= in_ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         a0_rej_ff  <= rej_in;
         a0_flip_ff <= in_ctl.flip ^ swap_in;
         a0_apl_ff  <= apl_in;
         a0_p1_ff   <= p1s_in;
         a0_q1_ff   <= q1s_in;
         a0_p2_ff   <= p2s_in;
         a0_q2_ff   <= q2s_in;
         a0_dl_ff   <= dl_in;
         a0_dq_ff   <= dq_in;
         a0_den_ff  <= den_in;
         a0_side_ff <= in_side;
      end
   end

   // ---------------- Stage A1: low-clip numerator product.
   logic                  a1_valid_ff, a1_rej_ff, a1_flip_ff, a1_apl_ff;
   logic signed [CW-1:0]  a1_p1_ff, a1_q1_ff, a1_p2_ff, a1_q2_ff;
   logic signed [DW-1:0]  a1_den_ff;
   logic signed [LNW-1:0] a1_prod_ff;
   logic [SIDE_BITS-1:0]  a1_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a1_valid_ff <= 1'b0;
      end else if (enable) begin
         a1_valid_ff <= a0_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         a1_rej_ff  <= a0_rej_ff;
         a1_flip_ff <= a0_flip_ff;
         a1_apl_ff  <= a0_apl_ff;
         a1_p1_ff   <= a0_p1_ff;
         a1_q1_ff   <= a0_q1_ff;
         a1_p2_ff   <= a0_p2_ff;
         a1_q2_ff   <= a0_q2_ff;
         a1_den_ff  <= a0_den_ff;
         a1_prod_ff <= a0_dl_ff * a0_dq_ff;
         a1_side_ff <= a0_side_ff;
      end
   end

   // ---------------- Low-clip divider.
   logic                  ld_valid;
   logic signed [LNW-1:0] ld_quo;
   logic [LSW-1:0]        ld_side;

   lrc_div #(
      .NUM_BITS  (LNW),
      .DEN_BITS  (DW),
      .SIDE_BITS (LSW)
   ) u_low_div (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (a1_valid_ff),
      .in_num    (a1_prod_ff),
      .in_den    (a1_den_ff),
      .in_side   ({a1_side_ff, a1_rej_ff, a1_flip_ff, a1_apl_ff,
                   a1_p1_ff, a1_q1_ff, a1_p2_ff, a1_q2_ff}),
      .out_valid (ld_valid),
      .out_quo   (ld_quo),
      .out_side  (ld_side)
   );

   // ---------------- Stage A2: apply the low clip.
   logic [SIDE_BITS-1:0]  ls_side;
   logic                  ls_rej, ls_flip, ls_apl;
   logic signed [CW-1:0]  ls_p1, ls_q1, ls_p2, ls_q2;
   logic signed [CW-1:0]  lq_sat_in;
   logic signed [CW:0]    lsum_in;
   logic signed [CW-1:0]  q1n_in, p1n_in;

   always_comb begin
      {ls_side, ls_rej, ls_flip, ls_apl, ls_p1, ls_q1, ls_p2, ls_q2} = ld_side;
      lq_sat_in = sat_coord(RNW'(ld_quo));
      lsum_in   = {ls_q1[CW-1], ls_q1} + {lq_sat_in[CW-1], lq_sat_in};
      q1n_in    = ls_apl ? sat_coord(RNW'(lsum_in)) : ls_q1;
      p1n_in    = ls_apl ? in_lo : ls_p1;
   end

   logic                  a2_valid_ff, a2_rej_ff, a2_flip_ff;
   logic signed [CW-1:0]  a2_p1_ff, a2_q1_ff, a2_p2_ff, a2_q2_ff;
   logic [SIDE_BITS-1:0]  a2_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a2_valid_ff <= 1'b0;
      end else if (enable) begin
         a2_valid_ff <= ld_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         a2_rej_ff  <= ls_rej;
         a2_flip_ff <= ls_flip;
         a2_p1_ff   <= p1n_in;
         a2_q1_ff   <= q1n_in;
         a2_p2_ff   <= ls_p2;
         a2_q2_ff   <= ls_q2;
         a2_side_ff <= ls_side;
      end
   end

   // ---------------- Stage A3: high-clip differences.
   logic                  a3_valid_ff, a3_rej_ff, a3_flip_ff, a3_aph_ff;
   logic signed [CW-1:0]  a3_p1_ff, a3_q1_ff, a3_p2_ff, a3_q2_ff;
   logic signed [DW-1:0]  a3_dx_ff, a3_da_ff, a3_db_ff;
   logic [SIDE_BITS-1:0]  a3_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a3_valid_ff <= 1'b0;
      end else if (enable) begin
         a3_valid_ff <= a2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         a3_rej_ff  <= a2_rej_ff;
         a3_flip_ff <= a2_flip_ff;
         a3_aph_ff  <= (a2_p2_ff > in_hi);
         a3_p1_ff   <= a2_p1_ff;
         a3_q1_ff   <= a2_q1_ff;
         a3_p2_ff   <= a2_p2_ff;
         a3_q2_ff   <= a2_q2_ff;
         a3_dx_ff   <= {a2_p2_ff[CW-1], a2_p2_ff} - {a2_p1_ff[CW-1], a2_p1_ff};
         a3_da_ff   <= {in_hi[CW-1], in_hi} - {a2_p1_ff[CW-1], a2_p1_ff};
         a3_db_ff   <= {a2_q2_ff[CW-1], a2_q2_ff} - {a2_q1_ff[CW-1], a2_q1_ff};
         a3_side_ff <= a2_side_ff;
      end
   end

   // ---------------- Stage A4: high-clip products.
   logic                    a4_valid_ff, a4_rej_ff, a4_flip_ff, a4_aph_ff;
   logic signed [CW-1:0]    a4_p1_ff, a4_q1_ff, a4_p2_ff, a4_q2_ff;
   logic signed [DW-1:0]    a4_dx_ff;
   logic signed [2*CW:0]    a4_m1_ff;
   logic signed [LNW-1:0]   a4_m2_ff;
   logic [SIDE_BITS-1:0]    a4_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a4_valid_ff <= 1'b0;
      end else if (enable) begin
         a4_valid_ff <= a3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         a4_rej_ff  <= a3_rej_ff;
         a4_flip_ff <= a3_flip_ff;
         a4_aph_ff  <= a3_aph_ff;
         a4_p1_ff   <= a3_p1_ff;
         a4_q1_ff   <= a3_q1_ff;
         a4_p2_ff   <= a3_p2_ff;
         a4_q2_ff   <= a3_q2_ff;
         a4_dx_ff   <= a3_dx_ff;
         a4_m1_ff   <= a3_q1_ff * a3_dx_ff;
         a4_m2_ff   <= a3_da_ff * a3_db_ff;
         a4_side_ff <= a3_side_ff;
      end
   end

   // ---------------- Stage A5: high-clip numerator sum.
   logic                  a5_valid_ff, a5_rej_ff, a5_flip_ff, a5_aph_ff, a5_dz_ff;
   logic signed [CW-1:0]  a5_p1_ff, a5_q1_ff, a5_p2_ff, a5_q2_ff;
   logic signed [DW-1:0]  a5_dx_ff;
   logic signed [RNW-1:0] a5_num_ff;
   logic [SIDE_BITS-1:0]  a5_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a5_valid_ff <= 1'b0;
      end else if (enable) begin
         a5_valid_ff <= a4_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         a5_rej_ff  <= a4_rej_ff;
         a5_flip_ff <= a4_flip_ff;
         a5_aph_ff  <= a4_aph_ff;
         a5_dz_ff   <= (a4_dx_ff == '0);
         a5_p1_ff   <= a4_p1_ff;
         a5_q1_ff   <= a4_q1_ff;
         a5_p2_ff   <= a4_p2_ff;
         a5_q2_ff   <= a4_q2_ff;
         a5_dx_ff   <= a4_dx_ff;
         a5_num_ff  <= RNW'(a4_m1_ff) + RNW'(a4_m2_ff);
         a5_side_ff <= a4_side_ff;
      end
   end

   // ---------------- High-clip divider.
   logic                  hd_valid;
   logic signed [RNW-1:0] hd_quo;
   logic [RSW-1:0]        hd_side;

   lrc_div #(
      .NUM_BITS  (RNW),
      .DEN_BITS  (DW),
      .SIDE_BITS (RSW)
   ) u_high_div (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (a5_valid_ff),
      .in_num    (a5_num_ff),
      .in_den    (a5_dx_ff),
      .in_side   ({a5_side_ff, a5_rej_ff, a5_flip_ff, a5_aph_ff, a5_dz_ff,
                   a5_p1_ff, a5_q1_ff, a5_p2_ff, a5_q2_ff}),
      .out_valid (hd_valid),
      .out_quo   (hd_quo),
      .out_side  (hd_side)
   );

   // ---------------- Stage A6: apply the high clip.
   logic [SIDE_BITS-1:0]  hs_side;
   logic                  hs_rej, hs_flip, hs_aph, hs_dz;
   logic signed [CW-1:0]  hs_p1, hs_q1, hs_p2, hs_q2;
   logic signed [CW-1:0]  q2r_in;

   always_comb begin
      {hs_side, hs_rej, hs_flip, hs_aph, hs_dz, hs_p1, hs_q1, hs_p2, hs_q2} = hd_side;
      q2r_in = hs_dz ? hs_q1 : sat_coord(hd_quo);
   end

   logic                  a6_valid_ff, a6_rej_ff, a6_flip_ff;
   logic signed [CW-1:0]  a6_p1_ff, a6_q1_ff, a6_p2_ff, a6_q2_ff;
   logic [SIDE_BITS-1:0]  a6_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a6_valid_ff <= 1'b0;
      end else if (enable) begin
         a6_valid_ff <= hd_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         a6_rej_ff  <= hs_rej;
         a6_flip_ff <= hs_flip;
         a6_p1_ff   <= hs_p1;
         a6_q1_ff   <= hs_q1;
         a6_p2_ff   <= hs_aph ? in_hi : hs_p2;
         a6_q2_ff   <= hs_aph ? q2r_in : hs_q2;
         a6_side_ff <= hs_side;
      end
   end

   assign out_ctl  = '{valid: a6_valid_ff, rej: a6_rej_ff, flip: a6_flip_ff};
   assign out_p1   = a6_p1_ff;
   assign out_q1   = a6_q1_ff;
   assign out_p2   = a6_p2_ff;
   assign out_q2   = a6_q2_ff;
   assign out_side = a6_side_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/line_rect_clip.sv =====
// Top level of the line rectangle clipper: window registers, x and y clip pipelines, output.
//
//   channel | direction | handshake            | carries
//   --------+-----------+----------------------+------------------------------------------
//   req     | in        | req_valid/req_ready  | first_x, first_y, second_x, second_y
//   rsp     | out       | rsp_valid/rsp_ready  | visible and the four clipped coordinates
//   csr     | in        | csr_we               | window register index and write data
//
// A line is taken every cycle unless the pipeline holds; its result is presented from the
// output register after the input register and the x and y clip pipelines.
// Most of the depth is in the four bit-serial divider pipelines, one quotient bit per stage.
// The whole pipeline advances together and holds only when its last stage carries a
// result and the output register is full and not being taken.
// Synchronous reset empties the pipeline and loads the default window.
`default_nettype none

module line_rect_clip #(
   parameter int COORD_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [COORD_BITS-1:0]         req_first_x,
   input  logic signed [COORD_BITS-1:0]         req_first_y,
   input  logic signed [COORD_BITS-1:0]         req_second_x,
   input  logic signed [COORD_BITS-1:0]         req_second_y,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_visible,
   output logic signed [COORD_BITS-1:0]         rsp_clipped_first_x,
   output logic signed [COORD_BITS-1:0]         rsp_clipped_first_y,
   output logic signed [COORD_BITS-1:0]         rsp_clipped_second_x,
   output logic signed [COORD_BITS-1:0]         rsp_clipped_second_y,
   input  logic                                 csr_we,
   input  logic [lrc_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [COORD_BITS-1:0]                csr_wdata
);
   import lrc_pkg::*;

   localparam int CW   = COORD_BITS;
   localparam int SIDE = 4 * CW;

   // Window registers.
   logic signed [CW-1:0] left_ff, right_ff, top_ff, bottom_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff   <= CW'(RESET_LEFT);
         right_ff  <= CW'(RESET_RIGHT);
         top_ff    <= CW'(RESET_TOP);
         bottom_ff <= CW'(RESET_BOTTOM);
      end else if (csr_we) begin
         unique case (lrc_csr_type'(csr_index))
            CSR_LEFT:   left_ff   <= csr_wdata;
            CSR_RIGHT:  right_ff  <= csr_wdata;
            CSR_TOP:    top_ff    <= csr_wdata;
            CSR_BOTTOM: bottom_ff <= csr_wdata;
            default:    left_ff   <= left_ff;
         endcase
      end
   end

   // Pipeline advance: hold only when a finished line cannot enter the output register.
   lrc_ctl_type          y_ctl;
   logic                 rsp_valid_ff;
   logic                 advance;

   assign advance   = !(y_ctl.valid && rsp_valid_ff && !rsp_ready);
   assign req_ready = advance;

   // Input register.
   logic                 t0_valid_ff;
   logic signed [CW-1:0] t0_x1_ff, t0_y1_ff, t0_x2_ff, t0_y2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         t0_valid_ff <= 1'b0;
      end else if (advance) begin
         t0_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         t0_x1_ff <= req_first_x;
         t0_y1_ff <= req_first_y;
         t0_x2_ff <= req_second_x;
         t0_y2_ff <= req_second_y;
      end
   end

   // Early reject on y; the x axis pipeline adds its own x test.
   lrc_ctl_type x_in_ctl;

   always_comb begin
      x_in_ctl.valid = t0_valid_ff;
      x_in_ctl.rej   = (t0_y1_ff > bottom_ff && t0_y2_ff > bottom_ff) ||
                       (t0_y1_ff < top_ff && t0_y2_ff < top_ff);
      x_in_ctl.flip  = 1'b0;
   end

   // Clip in x: the clipped axis is x, the interpolated one is y.
   lrc_ctl_type          x_ctl;
   logic signed [CW-1:0] x_x1, x_y1, x_x2, x_y2;
   logic [SIDE-1:0]      x_side;

   lrc_axis #(
      .CW        (CW),
      .SIDE_BITS (SIDE)
   ) u_x_axis (
      .clock    (clock),
      .reset    (reset),
      .enable   (advance),
      .in_ctl   (x_in_ctl),
      .in_p1    (t0_x1_ff),
      .in_q1    (t0_y1_ff),
      .in_p2    (t0_x2_ff),
      .in_q2    (t0_y2_ff),
      .in_lo    (left_ff),
      .in_hi    (right_ff),
      .in_side  ({t0_x1_ff, t0_y1_ff, t0_x2_ff, t0_y2_ff}),
      .out_ctl  (x_ctl),
      .out_p1   (x_x1),
      .out_q1   (x_y1),
      .out_p2   (x_x2),
      .out_q2   (x_y2),
      .out_side (x_side)
   );

   // Clip in y: the clipped axis is y, the interpolated one is x.
   logic signed [CW-1:0] y_x1, y_y1, y_x2, y_y2;
   logic [SIDE-1:0]      y_side;

   lrc_axis #(
      .CW        (CW),
      .SIDE_BITS (SIDE)
   ) u_y_axis (
      .clock    (clock),
      .reset    (reset),
      .enable   (advance),
      .in_ctl   (x_ctl),
      .in_p1    (x_y1),
      .in_q1    (x_x1),
      .in_p2    (x_y2),
      .in_q2    (x_x2),
      .in_lo    (top_ff),
      .in_hi    (bottom_ff),
      .in_side  (x_side),
      .out_ctl  (y_ctl),
      .out_p1   (y_y1),
      .out_q1   (y_x1),
      .out_p2   (y_y2),
      .out_q2   (y_x2),
      .out_side (y_side)
   );

   // Restore endpoint order, or pass the original endpoints of a rejected line.
   logic signed [CW-1:0] ofx_in, ofy_in, osx_in, osy_in;

   always_comb begin
      if (y_ctl.rej) begin
         {ofx_in, ofy_in, osx_in, osy_in} = y_side;
      end else if (y_ctl.flip) begin
         ofx_in = y_x2;
         ofy_in = y_y2;
         osx_in = y_x1;
         osy_in = y_y1;
      end else begin
         ofx_in = y_x1;
         ofy_in = y_y1;
         osx_in = y_x2;
         osy_in = y_y2;
      end
   end

   // Output register.
   logic                 rsp_visible_ff;
   logic signed [CW-1:0] rsp_fx_ff, rsp_fy_ff, rsp_sx_ff, rsp_sy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && y_ctl.valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && y_ctl.valid) begin
         rsp_visible_ff <= !y_ctl.rej;
         rsp_fx_ff      <= ofx_in;
         rsp_fy_ff      <= ofy_in;
         rsp_sx_ff      <= osx_in;
         rsp_sy_ff      <= osy_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_visible          = rsp_visible_ff;
   assign rsp_clipped_first_x  = rsp_fx_ff;
   assign rsp_clipped_first_y  = rsp_fy_ff;
   assign rsp_clipped_second_x = rsp_sx_ff;
   assign rsp_clipped_second_y = rsp_sy_ff;

   // The pipeline holds only while a finished line waits on a full output register.
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (y_ctl.valid && rsp_valid && !rsp_ready))
      else $error("pipeline held without a blocked output");

   // A finished line that moves on always lands in the output register.
   assert property (@(posedge clock) disable iff (reset)
      (y_ctl.valid && req_ready) |=> rsp_valid)
      else $error("finished line lost before the output register");

   // A taken result with nothing behind it empties the output register.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !y_ctl.valid) |=> !rsp_valid)
      else $error("result repeated after transfer");

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking testbench for the line rectangle clipper.
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import lrc_pkg::*;

   localparam int W = 16;
   localparam int LATENCY = 8 * W + 34;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef logic signed [W-1:0] coord_type;

   typedef struct packed {
      coord_type ax;
      coord_type ay;
      coord_type bx;
      coord_type by;
   } line_type;

   typedef struct packed {
      logic      visible;
      coord_type ax;
      coord_type ay;
      coord_type bx;
      coord_type by;
   } clip_type;

   logic      clock;
   logic      reset;
   logic      req_valid;
   logic      req_ready;
   coord_type req_first_x, req_first_y, req_second_x, req_second_y;
   logic      rsp_valid;
   logic      rsp_ready;
   logic      rsp_visible;
   coord_type rsp_clipped_first_x, rsp_clipped_first_y;
   coord_type rsp_clipped_second_x, rsp_clipped_second_y;
   logic      csr_we;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [W-1:0] csr_wdata;

   line_rect_clip #(.COORD_BITS(W)) DUT (.*);

   // Window copy used by the predictor.
   longint win_left, win_right, win_top, win_bottom;

   clip_type expected_clips[$];
   int       mismatch_count;
   int       lines_sent;
   int       clips_checked;
   int       rejects_seen;
   int       idle_cycles;
   logic     hold_off;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic longint clamp_coord(longint v);
      longint hi;
      hi = (64'sd1 <<< (W - 1)) - 1;
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
   endfunction

   function automatic longint quot(longint num, longint den);
      if (den == 0) return 0;
      return num / den;
   endfunction

   function automatic bit beyond(longint a, longint b, longint lo, longint hi);
      return (a > hi && b > hi) || (a < lo && b < lo);
   endfunction

   // Predict the clip of one line against the current window.
   function automatic clip_type clip_line(line_type ln);
      clip_type r;
      longint   x1, y1, x2, y2, t, d;
      bit       flip;
      x1 = longint'(ln.ax); y1 = longint'(ln.ay);
      x2 = longint'(ln.bx); y2 = longint'(ln.by);
      flip = 1'b0;
      r = {1'b0, ln.ax, ln.ay, ln.bx, ln.by};
      if (beyond(x1, x2, win_left, win_right) || beyond(y1, y2, win_top, win_bottom))
         return r;
      if (x1 > x2) begin
         t = x1; x1 = x2; x2 = t;
         t = y1; y1 = y2; y2 = t;
         flip = ~flip;
      end
      if (x1 < win_left) begin
         y1 = clamp_coord(y1 + clamp_coord(quot((win_left - x1) * (y2 - y1), x2 - x1)));
         x1 = win_left;
      end
      if (x2 > win_right) begin
         d = x2 - x1;
         y2 = clamp_coord(quot(y1 * d + (win_right - x1) * (y2 - y1), d));
         if (d == 0) y2 = y1;
         x2 = win_right;
      end
      if (beyond(y1, y2, win_top, win_bottom))
         return r;
      if (y1 > y2) begin
         t = x1; x1 = x2; x2 = t;
         t = y1; y1 = y2; y2 = t;
         flip = ~flip;
      end
      if (y1 < win_top) begin
         x1 = clamp_coord(x1 + clamp_coord(quot((win_top - y1) * (x2 - x1), y2 - y1)));
         y1 = win_top;
      end
      if (y2 > win_bottom) begin
         d = y2 - y1;
         x2 = clamp_coord(quot(x1 * d + (win_bottom - y1) * (x2 - x1), d));
         if (d == 0) x2 = x1;
         y2 = win_bottom;
      end
      if (flip)
         r = {1'b1, coord_type'(x2), coord_type'(y2), coord_type'(x1), coord_type'(y1)};
      else
         r = {1'b1, coord_type'(x1), coord_type'(y1), coord_type'(x2), coord_type'(y2)};
      return r;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch on %s at %0t: got %0d, expected %0d", what, $realtime, got, want);
      mismatch_count++;
   endtask

   // Check each result transfer against the oldest expectation.
   always @(posedge clock) begin
      clip_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_clips.size() == 0) begin
            report_mismatch("unexpected result", longint'(1), longint'(0));
         end else begin
            want = expected_clips.pop_front();
            if (rsp_visible !== want.visible)
               report_mismatch("visible", longint'(rsp_visible), longint'(want.visible));
            if (rsp_clipped_first_x !== want.ax)
               report_mismatch("clipped_first_x", longint'(rsp_clipped_first_x),
                               longint'(want.ax));
            if (rsp_clipped_first_y !== want.ay)
               report_mismatch("clipped_first_y", longint'(rsp_clipped_first_y),
                               longint'(want.ay));
            if (rsp_clipped_second_x !== want.bx)
               report_mismatch("clipped_second_x", longint'(rsp_clipped_second_x),
                               longint'(want.bx));
            if (rsp_clipped_second_y !== want.by)
               report_mismatch("clipped_second_y", longint'(rsp_clipped_second_y),
                               longint'(want.by));
            clips_checked++;
            if (!rsp_visible) rejects_seen++;
         end
      end
   end

   // Predict at the line transfer itself.
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         expected_clips.push_back(clip_line({req_first_x, req_first_y,
                                             req_second_x, req_second_y}));
         lines_sent++;
      end
   end

   // Watchdog on cycles without any transfer.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired at %0t", $realtime);
         $display("FAIL");
         $finish;
      end
   end

   // Receiver stalls on its own pattern, with one long hold-off on request.
   initial begin
      int mode;
      rsp_ready = 1'b0;
      @(negedge clock);
      forever begin
         mode = $urandom_range(0, 3);
         repeat ($urandom_range(5, 60)) begin
            @(negedge clock);
            if (hold_off) rsp_ready <= 1'b0;
            else if (mode == 0) rsp_ready <= 1'b1;
            else if (mode == 1) rsp_ready <= ($urandom_range(0, 3) != 0);
            else if (mode == 2) rsp_ready <= ($urandom_range(0, 1) == 1);
            else rsp_ready <= ($urandom_range(0, 3) == 0);
         end
      end
   end

   task automatic write_reg(lrc_csr_type idx, longint value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[W-1:0];
      @(negedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_LEFT:   win_left   = longint'(coord_type'(value[W-1:0]));
         CSR_RIGHT:  win_right  = longint'(coord_type'(value[W-1:0]));
         CSR_TOP:    win_top    = longint'(coord_type'(value[W-1:0]));
         CSR_BOTTOM: win_bottom = longint'(coord_type'(value[W-1:0]));
      endcase
   endtask

   task automatic set_window(longint l, longint r, longint t, longint b);
      write_reg(CSR_LEFT, l);
      write_reg(CSR_RIGHT, r);
      write_reg(CSR_TOP, t);
      write_reg(CSR_BOTTOM, b);
   endtask

   // Offer one line; the caller is at a falling edge.
   task automatic send_line(line_type ln);
      req_valid <= 1'b1;
      req_first_x <= ln.ax;
      req_first_y <= ln.ay;
      req_second_x <= ln.bx;
      req_second_y <= ln.by;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain;
      while (expected_clips.size() != 0) @(negedge clock);
      repeat (LATENCY + 10) @(negedge clock);
   endtask

   // Random coordinate, mostly near the window, sometimes anywhere.
   function automatic coord_type pick_coord(longint lo, longint hi);
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 6) return coord_type'(clamp_coord(longint'(int'($urandom_range(0, 1599)))
                                      - 500 + lo + ((hi - lo) >>> 1) - 300));
      if (sel < 8) return coord_type'($urandom);
      if (sel == 8) return coord_type'(lo + longint'(int'($urandom_range(0, 2))) - 1);
      return coord_type'(hi + longint'(int'($urandom_range(0, 2))) - 1);
   endfunction

   task automatic random_lines(int count);
      int burst;
      line_type ln;
      while (count > 0) begin
         burst = $urandom_range(1, 40);
         while (burst > 0 && count > 0) begin
            ln.ax = pick_coord(win_left, win_right);
            ln.ay = pick_coord(win_top, win_bottom);
            ln.bx = pick_coord(win_left, win_right);
            ln.by = pick_coord(win_top, win_bottom);
            send_line(ln);
            burst--;
            count--;
         end
         // A gap between bursts drops valid for a while.
         if ($urandom_range(0, 2) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clock);
         end
      end
      req_valid <= 1'b0;
   endtask

   // Directed lines under the reset window: stimulus and, where obvious, the answer.
   typedef struct {
      line_type ln;
      bit       known;
      clip_type want;
   } directed_row_type;

   directed_row_type directed_rows[] = '{
      // Fully inside: passes unchanged.
      '{'{16'sd10, 16'sd20, 16'sd30, 16'sd40}, 1'b1, '{1'b1, 16'sd10, 16'sd20, 16'sd30, 16'sd40}},
      // Both endpoints left of the window: rejected.
      '{'{-16'sd5, 16'sd1, -16'sd9, 16'sd2}, 1'b1, '{1'b0, -16'sd5, 16'sd1, -16'sd9, 16'sd2}},
      // Both below the bottom edge: rejected.
      '{'{16'sd1, 16'sd500, 16'sd2, 16'sd900}, 1'b1, '{1'b0, 16'sd1, 16'sd500, 16'sd2, 16'sd900}},
      // Extremes of the coordinate range, same side: rejected.
      '{'{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh8000}, 1'b1,
        '{1'b0, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh8000}},
      '{'{16'sh8000, 16'sh8000, 16'sh8000, 16'sh7FFF}, 1'b1,
        '{1'b0, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh7FFF}},
      // Horizontal line across the window.
      '{'{-16'sd100, 16'sd50, 16'sd800, 16'sd50}, 1'b1, '{1'b1, 16'sd0, 16'sd50, 16'sd639, 16'sd50}},
      // Same, reversed order.
      '{'{16'sd800, 16'sd50, -16'sd100, 16'sd50}, 1'b1, '{1'b1, 16'sd639, 16'sd50, 16'sd0, 16'sd50}},
      // Vertical line across the window.
      '{'{16'sd7, -16'sd100, 16'sd7, 16'sd900}, 1'b1, '{1'b1, 16'sd7, 16'sd0, 16'sd7, 16'sd479}},
      // Corners of the window and a single point.
      '{'{16'sd0, 16'sd0, 16'sd639, 16'sd479}, 1'b1, '{1'b1, 16'sd0, 16'sd0, 16'sd639, 16'sd479}},
      '{'{16'sd3, 16'sd3, 16'sd3, 16'sd3}, 1'b1, '{1'b1, 16'sd3, 16'sd3, 16'sd3, 16'sd3}},
      // Diagonals, full span, and cases rejected only after the x clip.
      '{'{16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh7FFF}, 1'b0, '{default: '0}},
      '{'{16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh7FFF}, 1'b0, '{default: '0}},
      '{'{-16'sd1000, -16'sd10, 16'sd100, 16'sd1000}, 1'b0, '{default: '0}},
      '{'{-16'sd10, 16'sd500, 16'sd700, -16'sd30}, 1'b0, '{default: '0}},
      '{'{-16'sd300, -16'sd1, 16'sd10, -16'sd400}, 1'b0, '{default: '0}},
      '{'{16'sd600, 16'sd470, 16'sd700, 16'sd600}, 1'b0, '{default: '0}},
      '{'{16'sd5, -16'sd50, 16'sd100, 16'sd700}, 1'b0, '{default: '0}}
   };

   initial begin
      mismatch_count = 0;
      lines_sent = 0;
      clips_checked = 0;
      rejects_seen = 0;
      hold_off = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_first_x = '0;
      req_first_y = '0;
      req_second_x = '0;
      req_second_y = '0;
      csr_we = 1'b0;
      csr_index = CSR_LEFT;
      csr_wdata = '0;
      win_left = longint'(RESET_LEFT);
      win_right = longint'(RESET_RIGHT);
      win_top = longint'(RESET_TOP);
      win_bottom = longint'(RESET_BOTTOM);
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed lines against the reset window.
      foreach (directed_rows[i]) begin
         if (directed_rows[i].known && clip_line(directed_rows[i].ln) != directed_rows[i].want)
            report_mismatch("predictor table row", longint'(i), longint'(i));
         send_line(directed_rows[i].ln);
      end
      req_valid <= 1'b0;
      drain();

      // Default window; long receiver hold-off while lines keep coming.
      hold_off = 1'b1;
      fork
         random_lines(400);
         begin
            repeat (LATENCY * 3) @(negedge clock);
            hold_off = 1'b0;
         end
      join
      drain();

      // Small window at an odd offset.
      set_window(-40, 25, 100, 131);
      random_lines(250);
      drain();

      // Window at the extremes of the range.
      set_window(-32768, 32767, -32768, 32767);
      random_lines(150);
      drain();

      // Inverted window: left above right, top above bottom.
      set_window(200, -200, 90, -90);
      random_lines(150);
      drain();

      // Degenerate single-point window at the largest x and the smallest y of the range.
      set_window(32767, 32767, -32768, -32768);
      random_lines(75);
      drain();

      // Back to a typical window.
      set_window(16, 1000, -300, 300);
      random_lines(75);
      drain();

      $display("Clipped %0d lines (%0d rejected) under six window settings.",
               clips_checked, rejects_seen);
      if (mismatch_count == 0 && expected_clips.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

`default_nettype wire
